// ===== rtl/core/rosp_pkg.sv =====
`default_nettype none
package rosp_pkg;

   localparam int unsigned WordWidthDefault   = 32;
   localparam int unsigned CordicStepsDefault = 24;
   localparam int unsigned CordicStepsMax     = 40;

   // Phase reduction: quotient bits resolved per stage and number of stages.
   // Eighteen quotient bits cover any 64-bit product since 2^64 < 2^18 * 2*pi in Q44.
   localparam int unsigned PhaseRemBits   = 2;
   localparam int unsigned PhaseRemStages = 9;

   localparam logic [31:0] MeanMotionReset    = 32'd4724464;
   localparam logic [31:0] MeanMotionRecReset = 32'd59578122;

   localparam logic [0:0] CsrMeanMotion    = 1'b0;
   localparam logic [0:0] CsrMeanMotionRec = 1'b1;

   // Wide working type: signed, saturated to +-(2^62 - 1).
   typedef logic signed [63:0] wide_type;

   localparam wide_type      Lim       = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic [47:0]   TwoPiQ44  = 48'd110534964875446;
   localparam wide_type      PiQ30     = 64'sd3373259426;
   localparam wide_type      HalfPiQ30 = 64'sd1686629713;
   localparam wide_type      OneQ30    = 64'sd1073741824;
   localparam wide_type      GainQ30   = 64'sd652032874;

   typedef struct packed {
      logic [31:0] t;
      logic signed [31:0] x0;
      logic signed [31:0] y0;
      logic signed [31:0] z0;
      logic signed [31:0] vx0;
      logic signed [31:0] vy0;
      logic signed [31:0] vz0;
   } state_type;

   function automatic wide_type atan_q30(input int unsigned i);
      unique case (i)
         0: atan_q30 = 64'sd843314856;
         1: atan_q30 = 64'sd497837829;
         2: atan_q30 = 64'sd263043836;
         3: atan_q30 = 64'sd133525158;
         4: atan_q30 = 64'sd67021686;
         5: atan_q30 = 64'sd33543515;
         6: atan_q30 = 64'sd16775850;
         7: atan_q30 = 64'sd8388437;
         8: atan_q30 = 64'sd4194282;
         9: atan_q30 = 64'sd2097149;
         10: atan_q30 = 64'sd1048575;
         11: atan_q30 = 64'sd524287;
         12: atan_q30 = 64'sd262143;
         13: atan_q30 = 64'sd131071;
         14: atan_q30 = 64'sd65535;
         15: atan_q30 = 64'sd32767;
         16: atan_q30 = 64'sd16383;
         17: atan_q30 = 64'sd8191;
         18: atan_q30 = 64'sd4095;
         19: atan_q30 = 64'sd2047;
         20: atan_q30 = 64'sd1023;
         21: atan_q30 = 64'sd511;
         22: atan_q30 = 64'sd255;
         23: atan_q30 = 64'sd127;
         24: atan_q30 = 64'sd63;
         25: atan_q30 = 64'sd31;
         26: atan_q30 = 64'sd15;
         27: atan_q30 = 64'sd8;
         28: atan_q30 = 64'sd4;
         29: atan_q30 = 64'sd2;
         30: atan_q30 = 64'sd1;
         default: atan_q30 = 64'sd0;
      endcase
   endfunction

   function automatic wide_type sat_add(input wide_type a, input wide_type b);
      logic signed [64:0] r;
      r = 65'(a) + 65'(b);
      if (r > 65'(Lim)) sat_add = Lim;
      else if (r < -65'(Lim)) sat_add = -Lim;
      else sat_add = r[63:0];
   endfunction

   // Saturate a signed value to a result word of w bits (w at most 32).
   function automatic logic [31:0] pack(input wide_type v, input int unsigned w);
      wide_type top;
      wide_type r;
      top = (64'sd1 <<< (w - 1)) - 64'sd1;
      r = v;
      if (r > top) r = top;
      if (r < -top - 64'sd1) r = -top - 64'sd1;
      pack = r[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/relative_orbit_state_propagator.sv =====
`default_nettype none
// Throughput: one request per cycle; the phase reduction, CORDIC and multipliers are
// fully pipelined, and the whole pipeline advances only when its last stage may move.
// Reset: synchronous, active high; clears the valid bits and loads the mean motion
// registers with their default values.
module relative_orbit_state_propagator #(
   parameter int unsigned WORD_WIDTH   = rosp_pkg::WordWidthDefault,
   parameter int unsigned CORDIC_STEPS = rosp_pkg::CordicStepsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [31:0]  csr_wdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // elapsed_time, start_radial, start_along, start_cross,
   // start_radial_rate, start_along_rate, start_cross_rate (lowest first)
   input  wire logic [223:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // end_radial, end_along, end_cross, end_radial_rate, end_along_rate,
   // end_cross_rate (lowest first)
   output logic [191:0]      rsp_tdata
);
   localparam int unsigned Steps = (CORDIC_STEPS < rosp_pkg::CordicStepsMax) ?
                                   CORDIC_STEPS : rosp_pkg::CordicStepsMax;
   localparam int unsigned OutW = (WORD_WIDTH > 32) ? 32 : WORD_WIDTH;
   // Stage 0 input reg, 1 nt mul, reduction stages plus its input reg, 1 fold,
   // Steps CORDIC, then 2 level-B multiply, 1 final sums and 1 output pack.
   localparam int unsigned SinLat = Steps + rosp_pkg::PhaseRemStages + 3;
   localparam int unsigned Lat = SinLat + 4;

   logic [31:0] n_ff, rn_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= rosp_pkg::MeanMotionReset;
         rn_ff <= rosp_pkg::MeanMotionRecReset;
      end else if (csr_we) begin
         unique case (csr_index)
            rosp_pkg::CsrMeanMotion: n_ff <= csr_wdata;
            rosp_pkg::CsrMeanMotionRec: rn_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline moves as a whole; an output register with the last stage.
   logic en;
   logic v_ff [0:Lat];
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v_ff[Lat];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= Lat; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_tvalid;
         for (int i = 1; i <= Lat; i++) v_ff[i] <= v_ff[i - 1];
      end
   end

   // Request registers, carried alongside in a delay line.
   rosp_pkg::state_type st_ff [0:Lat];
   logic [31:0] n_d_ff [0:Lat];
   logic [31:0] rn_d_ff [0:Lat];
   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= {req_tdata[31:0], req_tdata[63:32], req_tdata[95:64],
                      req_tdata[127:96], req_tdata[159:128], req_tdata[191:160],
                      req_tdata[223:192]};
         n_d_ff[0] <= n_ff;
         rn_d_ff[0] <= rn_ff;
         for (int i = 1; i <= Lat; i++) begin
            st_ff[i] <= st_ff[i - 1];
            n_d_ff[i] <= n_d_ff[i - 1];
            rn_d_ff[i] <= rn_d_ff[i - 1];
         end
      end
   end

   // nt = n * t, registered.
   logic [63:0] nt_ff;
   always_ff @(posedge clock) begin
      if (en) nt_ff <= 64'(n_d_ff[0]) * 64'(st_ff[0].t);
   end

   rosp_pkg::wide_type s, c;
   rosp_cordic #(.CORDIC_STEPS(Steps)) u_cordic (
      .clock(clock), .en(en), .nt(nt_ff), .sin_q30(s), .cos_q30(c)
   );

   // Sine and cosine emerge aligned with st_ff[SinLat]. Terms not depending on
   // them are computed from earlier stages so they line up.
   rosp_pkg::state_type q;
   assign q = st_ff[SinLat - 2];
   rosp_pkg::wide_type x0q, z0q, vx0q, vy0q, vz0q, nq, rnq, tq;
   assign x0q = 64'(q.x0);
   assign z0q = 64'(q.z0);
   assign vx0q = 64'(q.vx0);
   assign vy0q = 64'(q.vy0);
   assign vz0q = 64'(q.vz0);
   assign nq = 64'(n_d_ff[SinLat - 2]);
   assign rnq = 64'(rn_d_ff[SinLat - 2]);
   assign tq = 64'(q.t);

   // A fresh n * t, registered one stage ahead so it lines up with q. It can
   // exceed 2^63 - 1, so its multiplier treats it as unsigned.
   logic [63:0] ntq_ff;
   always_ff @(posedge clock) begin
      if (en) ntq_ff <= 64'(n_d_ff[SinLat - 3]) * 64'(st_ff[SinLat - 3].t);
   end

   // Level A: products available at SinLat.
   rosp_pkg::wide_type a, b, w, nx0, nz0, xnt, vyt;
   rosp_mul #(.SHIFT(16)) u_a (.clock(clock), .en(en), .a(vx0q), .b(rnq), .p(a));
   rosp_mul #(.SHIFT(16)) u_b (.clock(clock), .en(en), .a(vy0q), .b(rnq), .p(b));
   rosp_mul #(.SHIFT(16)) u_w (.clock(clock), .en(en), .a(vz0q), .b(rnq), .p(w));
   rosp_mul #(.SHIFT(16)) u_nx (.clock(clock), .en(en), .a(x0q), .b(nq), .p(nx0));
   rosp_mul #(.SHIFT(16)) u_nz (.clock(clock), .en(en), .a(z0q), .b(nq), .p(nz0));
   rosp_mul #(.SHIFT(44), .B_SIGNED(1'b0)) u_xnt (
      .clock(clock), .en(en), .a(x0q), .b(ntq_ff), .p(xnt)
   );
   rosp_mul #(.SHIFT(12)) u_vyt (.clock(clock), .en(en), .a(vy0q), .b(tq), .p(vyt));

   rosp_pkg::state_type r;
   assign r = st_ff[SinLat];
   rosp_pkg::wide_type x0, y0, z0, vx0, vy0, vz0, p;
   assign x0 = 64'(r.x0);
   assign y0 = 64'(r.y0);
   assign z0 = 64'(r.z0);
   assign vx0 = 64'(r.vx0);
   assign vy0 = 64'(r.vy0);
   assign vz0 = 64'(r.vz0);

   function automatic rosp_pkg::wide_type sm(input rosp_pkg::wide_type v,
                                             input int unsigned k);
      logic signed [67:0] e;
      e = 68'(v) * 68'(k);
      if (e > 68'(rosp_pkg::Lim)) sm = rosp_pkg::Lim;
      else if (e < -68'(rosp_pkg::Lim)) sm = -rosp_pkg::Lim;
      else sm = e[63:0];
   endfunction

   assign p = rosp_pkg::sat_add(sm(x0, 3), sm(b, 2));

   // Level B: products with sine and cosine, available at SinLat + 2.
   rosp_pkg::wide_type cm1, c43;
   assign cm1 = c - rosp_pkg::OneQ30;
   assign c43 = 4 * c - 3 * rosp_pkg::OneQ30;
   rosp_pkg::wide_type as_, pc, ps, ac, zc, ws, nxs, vxc, vys, nxc, vxs, vyc, nzs, vzc;
   rosp_mul #(.SHIFT(30)) u_as (.clock(clock), .en(en), .a(a), .b(s), .p(as_));
   rosp_mul #(.SHIFT(30)) u_pc (.clock(clock), .en(en), .a(p), .b(c), .p(pc));
   rosp_mul #(.SHIFT(30)) u_ps (.clock(clock), .en(en), .a(p), .b(s), .p(ps));
   rosp_mul #(.SHIFT(30)) u_ac (.clock(clock), .en(en), .a(a), .b(c), .p(ac));
   rosp_mul #(.SHIFT(30)) u_zc (.clock(clock), .en(en), .a(z0), .b(c), .p(zc));
   rosp_mul #(.SHIFT(30)) u_ws (.clock(clock), .en(en), .a(w), .b(s), .p(ws));
   rosp_mul #(.SHIFT(46)) u_nxs (.clock(clock), .en(en), .a(nx0), .b(s), .p(nxs));
   rosp_mul #(.SHIFT(30)) u_vxc (.clock(clock), .en(en), .a(vx0), .b(c), .p(vxc));
   rosp_mul #(.SHIFT(30)) u_vys (.clock(clock), .en(en), .a(vy0), .b(s), .p(vys));
   rosp_mul #(.SHIFT(46)) u_nxc (.clock(clock), .en(en), .a(nx0), .b(cm1), .p(nxc));
   rosp_mul #(.SHIFT(30)) u_vxs (.clock(clock), .en(en), .a(vx0), .b(s), .p(vxs));
   rosp_mul #(.SHIFT(30)) u_vyc (.clock(clock), .en(en), .a(vy0), .b(c43), .p(vyc));
   rosp_mul #(.SHIFT(46)) u_nzs (.clock(clock), .en(en), .a(nz0), .b(s), .p(nzs));
   rosp_mul #(.SHIFT(30)) u_vzc (.clock(clock), .en(en), .a(vz0), .b(c), .p(vzc));

   // Carry the sine-independent level A terms two stages to meet level B.
   rosp_pkg::wide_type xa_ff [0:1], ya_ff [0:1];
   rosp_pkg::wide_type xa_in, ya_in;
   always_comb begin
      xa_in = rosp_pkg::sat_add(sm(x0, 4), sm(b, 2));
      ya_in = rosp_pkg::sat_add(y0, -sm(a, 2));
      ya_in = rosp_pkg::sat_add(ya_in, -sm(xnt, 6));
      ya_in = rosp_pkg::sat_add(ya_in, -sm(vyt, 3));
   end
   always_ff @(posedge clock) begin
      if (en) begin
         xa_ff[0] <= xa_in;
         ya_ff[0] <= ya_in;
         xa_ff[1] <= xa_ff[0];
         ya_ff[1] <= ya_ff[0];
      end
   end

   // Final sums: registered two stages (split sums then pack).
   rosp_pkg::wide_type e_in [0:5];
   rosp_pkg::wide_type e_ff [0:5];
   always_comb begin
      e_in[0] = rosp_pkg::sat_add(rosp_pkg::sat_add(xa_ff[1], as_), -pc);
      e_in[1] = rosp_pkg::sat_add(rosp_pkg::sat_add(ya_ff[1], sm(ps, 2)), sm(ac, 2));
      e_in[2] = rosp_pkg::sat_add(zc, ws);
      e_in[3] = rosp_pkg::sat_add(rosp_pkg::sat_add(sm(nxs, 3), vxc), sm(vys, 2));
      e_in[4] = rosp_pkg::sat_add(rosp_pkg::sat_add(sm(nxc, 6), -sm(vxs, 2)), vyc);
      e_in[5] = rosp_pkg::sat_add(-nzs, vzc);
   end

   logic [191:0] out_in, out_ff;
   always_comb begin
      for (int k = 0; k < 6; k++) out_in[32 * k +: 32] = rosp_pkg::pack(e_ff[k], OutW);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 6; k++) e_ff[k] <= e_in[k];
         out_ff <= out_in;
      end
   end

   assign rsp_tdata = out_ff;
endmodule
`default_nettype wire

// ===== rtl/core/rosp_mul.sv =====
`default_nettype none
// Signed multiply with truncation toward zero after a right shift and saturation to +-Lim.
// Split into a partial-product stage and a combine stage, two registers deep.
// With B_SIGNED clear, b is taken as an unsigned 64-bit magnitude.
module rosp_mul #(
   parameter int unsigned SHIFT = 30,
   parameter bit          B_SIGNED = 1'b1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire rosp_pkg::wide_type a,
   input  wire rosp_pkg::wide_type b,
   output rosp_pkg::wide_type    p
);
   logic [63:0] ma, mb;
   logic        neg_in, neg_ff;
   logic [63:0] ll_in, lh_in, hl_in, hh_in;
   logic [63:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [127:0] full;
   logic [127:0] shifted;
   logic [63:0]  val;
   rosp_pkg::wide_type p_in, p_ff;

   always_comb begin
      ma = a[63] ? 64'(-a) : 64'(a);
      mb = (B_SIGNED && b[63]) ? 64'(-b) : 64'(b);
      neg_in = a[63] ^ (B_SIGNED && b[63]);
      ll_in = 64'(ma[31:0]) * 64'(mb[31:0]);
      lh_in = 64'(ma[31:0]) * 64'(mb[63:32]);
      hl_in = 64'(ma[63:32]) * 64'(mb[31:0]);
      hh_in = 64'(ma[63:32]) * 64'(mb[63:32]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
         neg_ff <= neg_in;
      end
   end

   always_comb begin
      full = 128'(ll_ff) + (128'(lh_ff) << 32) + (128'(hl_ff) << 32) + (128'(hh_ff) << 64);
      shifted = full >> SHIFT;
      if (shifted[127:62] != '0) val = 64'(rosp_pkg::Lim);
      else val = shifted[63:0];
      p_in = neg_ff ? -rosp_pkg::wide_type'(val) : rosp_pkg::wide_type'(val);
   end

   always_ff @(posedge clock) begin
      if (en) p_ff <= p_in;
   end

   assign p = p_ff;
endmodule
`default_nettype wire

// ===== rtl/core/rosp_cordic.sv =====
`default_nettype none
// Phase reduction and pipelined rotation-mode CORDIC, one step per stage.
module rosp_cordic #(
   parameter int unsigned CORDIC_STEPS = rosp_pkg::CordicStepsDefault
) (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] nt,
   output rosp_pkg::wide_type sin_q30,
   output rosp_pkg::wide_type cos_q30
);
   localparam int unsigned Steps = (CORDIC_STEPS < rosp_pkg::CordicStepsMax) ?
                                   CORDIC_STEPS : rosp_pkg::CordicStepsMax;
   localparam int unsigned RemStages = rosp_pkg::PhaseRemStages;
   localparam int unsigned RemBits = rosp_pkg::PhaseRemBits;

   // Reduction: 64-bit value modulo 2*pi in Q44 by restoring subtraction,
   // two quotient bits per stage over nine stages, highest quotient bit first.
   logic [63:0] rem_ff [0:RemStages];
   logic [63:0] rem_in [1:RemStages];

   always_comb begin
      for (int s = 0; s < RemStages; s++) begin
         logic [63:0] r;
         r = rem_ff[s];
         for (int k = RemBits - 1; k >= 0; k--) begin
            logic [63:0] d;
            d = 64'(rosp_pkg::TwoPiQ44) << (RemBits * (RemStages - 1 - s) + k);
            if (r >= d) r = r - d;
         end
         rem_in[s + 1] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= nt;
         for (int s = 1; s <= RemStages; s++) rem_ff[s] <= rem_in[s];
      end
   end

   rosp_pkg::wide_type ph0;
   logic               flip0;
   always_comb begin
      ph0 = rosp_pkg::wide_type'(rem_ff[RemStages] >> 14);
      flip0 = 1'b0;
      if (ph0 > rosp_pkg::PiQ30) ph0 = ph0 - 2 * rosp_pkg::PiQ30;
      if (ph0 > rosp_pkg::HalfPiQ30) begin
         ph0 = ph0 - rosp_pkg::PiQ30;
         flip0 = 1'b1;
      end else if (ph0 < -rosp_pkg::HalfPiQ30) begin
         ph0 = ph0 + rosp_pkg::PiQ30;
         flip0 = 1'b1;
      end
   end

   rosp_pkg::wide_type x_ff [0:Steps];
   rosp_pkg::wide_type y_ff [0:Steps];
   rosp_pkg::wide_type z_ff [0:Steps];
   logic               f_ff [0:Steps];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= rosp_pkg::GainQ30;
         y_ff[0] <= '0;
         z_ff[0] <= ph0;
         f_ff[0] <= flip0;
         for (int i = 0; i < Steps; i++) begin
            if (!z_ff[i][63]) begin
               x_ff[i + 1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i + 1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i + 1] <= z_ff[i] - rosp_pkg::atan_q30(i);
            end else begin
               x_ff[i + 1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i + 1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i + 1] <= z_ff[i] + rosp_pkg::atan_q30(i);
            end
            f_ff[i + 1] <= f_ff[i];
         end
      end
   end

   assign cos_q30 = f_ff[Steps] ? -x_ff[Steps] : x_ff[Steps];
   assign sin_q30 = f_ff[Steps] ? -y_ff[Steps] : y_ff[Steps];
endmodule
`default_nettype wire
